[rtl/core/pid_controller_clamped_macros.svh]
// ----------------------------------------------------------------------------
// pid_controller_clamped_macros.svh
// Assertion macros used by the PID controller sequencer.
// ----------------------------------------------------------------------------
`ifndef PID_CONTROLLER_CLAMPED_MACROS_SVH
`define PID_CONTROLLER_CLAMPED_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define PIDC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define PIDC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/pidc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pidc_pkg
// Shared types and constants of the clamped PID controller.
// ----------------------------------------------------------------------------
package pidc_pkg;

    // Configuration port geometry
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int IDX_W  = 3;
    localparam int GAIN_W = 16;

    // Register map, word index
    typedef enum logic [IDX_W-1:0] {
        REG_SETPOINT    = 3'd0,
        REG_KP          = 3'd1,
        REG_KI          = 3'd2,
        REG_KD          = 3'd3,
        REG_DRIVE_LIMIT = 3'd4,
        REG_TIME_STEP   = 3'd5
    } pidc_reg_idx_t;

    localparam logic [GAIN_W-1:0] DRIVE_LIMIT_RST = 16'hFFFF;
    localparam logic [GAIN_W-1:0] TIME_STEP_RST   = 16'd1;

    // Integral term is held to +/- 2^62 in a 64-bit word
    localparam int ITERM_W   = 64;
    localparam int KI_CAP_LSB = 62;
    localparam int TOTAL_W   = ITERM_W + 1;

    // Gain and limit registers
    typedef struct packed {
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] kd;
        logic [GAIN_W-1:0] drive_limit;
        logic [GAIN_W-1:0] time_step;
    } pidc_gains_t;

    // Sequencer to datapath commands
    typedef struct packed {
        logic load;
        logic imul;
        logic iadd;
        logic div_step;
        logic ki_init;
        logic ki_step;
        logic terms;
        logic sum;
        logic total;
        logic out_load;
    } pidc_cmd_t;

    // Datapath to sequencer status
    typedef struct packed {
        logic ts_zero;
    } pidc_stat_t;

endpackage

`default_nettype wire

[rtl/core/pidc_regs.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pidc_regs
// APB register file: setpoint, gains, drive limit and time step.
// ----------------------------------------------------------------------------
module pidc_regs #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [pidc_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [pidc_pkg::DATA_W-1:0]    pwdata,
    output logic      [pidc_pkg::DATA_W-1:0]    prdata,
    output logic                                pready,
    output logic      [SAMPLE_WIDTH-1:0]        setpoint,
    output pidc_pkg::pidc_gains_t               gains
);

    logic [SAMPLE_WIDTH-1:0]       setpoint_reg;
    pidc_pkg::pidc_gains_t         gains_reg;
    pidc_pkg::pidc_reg_idx_t       idx;
    logic                          wr_en;

    assign idx    = pidc_pkg::pidc_reg_idx_t'(paddr[pidc_pkg::ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    // Write registers at the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_reg          <= '0;
            gains_reg.kp          <= '0;
            gains_reg.ki          <= '0;
            gains_reg.kd          <= '0;
            gains_reg.drive_limit <= pidc_pkg::DRIVE_LIMIT_RST;
            gains_reg.time_step   <= pidc_pkg::TIME_STEP_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                pidc_pkg::REG_SETPOINT:    setpoint_reg <= pwdata[SAMPLE_WIDTH-1:0];
                pidc_pkg::REG_KP:          gains_reg.kp <= pwdata[pidc_pkg::GAIN_W-1:0];
                pidc_pkg::REG_KI:          gains_reg.ki <= pwdata[pidc_pkg::GAIN_W-1:0];
                pidc_pkg::REG_KD:          gains_reg.kd <= pwdata[pidc_pkg::GAIN_W-1:0];
                pidc_pkg::REG_DRIVE_LIMIT:
                    gains_reg.drive_limit <= pwdata[pidc_pkg::GAIN_W-1:0];
                pidc_pkg::REG_TIME_STEP:
                    gains_reg.time_step <= pwdata[pidc_pkg::GAIN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Return the addressed register
    always_comb
    begin
        case (idx)
            pidc_pkg::REG_SETPOINT:    prdata = pidc_pkg::DATA_W'(setpoint_reg);
            pidc_pkg::REG_KP:          prdata = pidc_pkg::DATA_W'(gains_reg.kp);
            pidc_pkg::REG_KI:          prdata = pidc_pkg::DATA_W'(gains_reg.ki);
            pidc_pkg::REG_KD:          prdata = pidc_pkg::DATA_W'(gains_reg.kd);
            pidc_pkg::REG_DRIVE_LIMIT: prdata = pidc_pkg::DATA_W'(gains_reg.drive_limit);
            pidc_pkg::REG_TIME_STEP:   prdata = pidc_pkg::DATA_W'(gains_reg.time_step);
            default:                   prdata = '0;
        endcase
    end

    assign setpoint = setpoint_reg;
    assign gains    = gains_reg;

endmodule

`default_nettype wire

[rtl/core/pidc_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pidc_dpath
// PID datapath: error, saturating integral, serial divider, serial ki
// multiply, term sum, clamp and output register.
// ----------------------------------------------------------------------------
module pidc_dpath #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int ACCUM_WIDTH  = 48
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire pidc_pkg::pidc_cmd_t          cmd,
    output pidc_pkg::pidc_stat_t              stat,
    input  wire logic [SAMPLE_WIDTH-1:0]      setpoint,
    input  wire pidc_pkg::pidc_gains_t        gains,
    input  wire logic [SAMPLE_WIDTH-1:0]      measurement,
    output logic      [pidc_pkg::GAIN_W-1:0]  drive,
    output logic      [SAMPLE_WIDTH:0]        error_now
);

    localparam int EW    = SAMPLE_WIDTH + 1;              // error
    localparam int DFW   = SAMPLE_WIDTH + 2;              // error difference
    localparam int QW    = SAMPLE_WIDTH + 1;              // quotient magnitude
    localparam int AW    = ACCUM_WIDTH;
    localparam int PW    = SAMPLE_WIDTH + 17;             // error times 16-bit value
    localparam int SUMW  = ((AW > PW) ? AW : PW) + 1;
    localparam int KC    = (AW + 15) / 16;
    localparam int MAGW  = KC * 16;
    localparam int PRODW = MAGW + 16;
    localparam int PEXT  = (PRODW > pidc_pkg::ITERM_W) ? PRODW : pidc_pkg::ITERM_W;
    localparam int DTW   = SAMPLE_WIDTH + 18;
    localparam int PDW   = SAMPLE_WIDTH + 19;
    localparam int TW    = pidc_pkg::TOTAL_W;
    localparam int GW    = pidc_pkg::GAIN_W;

    localparam logic signed [SUMW-1:0] A_HI = {{(SUMW-AW+1){1'b0}}, {(AW-1){1'b1}}};
    localparam logic signed [SUMW-1:0] A_LO = {{(SUMW-AW+1){1'b1}}, {(AW-1){1'b0}}};
    localparam logic [PEXT-1:0] KI_CAP =
        {{(PEXT-pidc_pkg::KI_CAP_LSB-1){1'b0}}, 1'b1, {pidc_pkg::KI_CAP_LSB{1'b0}}};

    // State and working registers
    logic signed [EW-1:0]     prev_reg;
    logic signed [AW-1:0]     integ_reg;
    logic signed [EW-1:0]     err_reg;
    logic signed [PW-1:0]     addend_reg;
    logic        [QW-1:0]     quo_reg;
    logic        [GW-1:0]     rem_reg;
    logic                     dneg_reg;
    logic        [MAGW-1:0]   kmag_reg;
    logic                     kneg_reg;
    logic        [PRODW-1:0]  prod_reg;
    logic signed [PW-1:0]     pterm_reg;
    logic signed [DTW-1:0]    dterm_reg;
    logic signed [pidc_pkg::ITERM_W-1:0] iterm_reg;
    logic signed [PDW-1:0]    pd_reg;
    logic signed [TW-1:0]     total_reg;
    logic        [GW-1:0]     drive_reg;
    logic signed [EW-1:0]     error_out_reg;

    // Combinational helpers
    logic signed [EW-1:0]     sp_ext;
    logic signed [EW-1:0]     meas_ext;
    logic signed [EW-1:0]     err_calc;
    logic signed [DFW-1:0]    diff_calc;
    logic signed [DFW-1:0]    diff_mag;
    logic signed [PW-1:0]     addend_calc;
    logic signed [SUMW-1:0]   sum_calc;
    logic signed [AW-1:0]     integ_sat;
    logic        [GW:0]       rem_shift;
    logic        [GW:0]       rem_sub;
    logic                     rem_ge;
    logic        [AW-1:0]     imag;
    logic        [31:0]       part_calc;
    logic        [PEXT-1:0]   prod_ext;
    logic        [PEXT-1:0]   prod_cap;
    logic signed [pidc_pkg::ITERM_W-1:0] cap_low;
    logic signed [pidc_pkg::ITERM_W-1:0] iterm_calc;
    logic signed [DFW-1:0]    deriv;
    logic signed [PW-1:0]     pterm_calc;
    logic signed [DTW-1:0]    dterm_calc;
    logic        [GW-1:0]     drive_calc;

    assign stat.ts_zero = (gains.time_step == '0);

    // Error and difference against the previous error
    assign sp_ext    = EW'($signed(setpoint));
    assign meas_ext  = EW'($signed(measurement));
    assign err_calc  = sp_ext - meas_ext;
    assign diff_calc = DFW'(err_calc) - DFW'(prev_reg);
    assign diff_mag  = diff_calc[DFW-1] ? -diff_calc : diff_calc;

    // Integral addend and saturating update
    assign addend_calc = $signed(err_reg) * $signed({1'b0, gains.time_step});
    assign sum_calc    = SUMW'(integ_reg) + SUMW'(addend_reg);

    always_comb
    begin
        if (sum_calc > A_HI)
        begin
            integ_sat = A_HI[AW-1:0];
        end
        else if (sum_calc < A_LO)
        begin
            integ_sat = A_LO[AW-1:0];
        end
        else
        begin
            integ_sat = sum_calc[AW-1:0];
        end
    end

    // Restoring divide step, one quotient bit per cycle
    assign rem_shift = {rem_reg, quo_reg[QW-1]};
    assign rem_sub   = rem_shift - {1'b0, gains.time_step};
    assign rem_ge    = (rem_shift >= {1'b0, gains.time_step});

    // ki times integral magnitude, one 16-bit chunk per cycle from the top
    assign imag      = integ_reg[AW-1] ? AW'(-integ_reg) : AW'(integ_reg);
    assign part_calc = kmag_reg[MAGW-1 -: 16] * gains.ki;

    // Cap the integral term and restore its sign
    assign prod_ext   = PEXT'(prod_reg);
    assign prod_cap   = (prod_ext > KI_CAP) ? KI_CAP : prod_ext;
    assign cap_low    = $signed(prod_cap[pidc_pkg::ITERM_W-1:0]);
    assign iterm_calc = kneg_reg ? -cap_low : cap_low;

    // Proportional and derivative terms
    always_comb
    begin
        if (stat.ts_zero)
        begin
            deriv = '0;
        end
        else if (dneg_reg)
        begin
            deriv = -$signed(DFW'(quo_reg));
        end
        else
        begin
            deriv = $signed(DFW'(quo_reg));
        end
    end

    assign pterm_calc = $signed(err_reg) * $signed({1'b0, gains.kp});
    assign dterm_calc = $signed(deriv) * $signed({1'b0, gains.kd});

    // Clamp the total to 0..drive_limit
    always_comb
    begin
        if (total_reg[TW-1])
        begin
            drive_calc = '0;
        end
        else if (total_reg > TW'(gains.drive_limit))
        begin
            drive_calc = gains.drive_limit;
        end
        else
        begin
            drive_calc = total_reg[GW-1:0];
        end
    end

    // Hold controller state across samples
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= '0;
            integ_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                prev_reg <= err_calc;
            end
            if (cmd.iadd)
            begin
                integ_reg <= integ_sat;
            end
        end
    end

    // Advance the working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            err_reg  <= err_calc;
            quo_reg  <= diff_mag[QW-1:0];
            rem_reg  <= '0;
            dneg_reg <= diff_calc[DFW-1];
        end
        if (cmd.imul)
        begin
            addend_reg <= addend_calc;
        end
        if (cmd.div_step)
        begin
            rem_reg <= rem_ge ? rem_sub[GW-1:0] : rem_shift[GW-1:0];
            quo_reg <= {quo_reg[QW-2:0], rem_ge};
        end
        if (cmd.ki_init)
        begin
            kmag_reg <= MAGW'(imag);
            kneg_reg <= integ_reg[AW-1];
            prod_reg <= '0;
        end
        if (cmd.ki_step)
        begin
            kmag_reg <= {kmag_reg[MAGW-17:0], 16'b0};
            prod_reg <= {prod_reg[PRODW-17:0], 16'b0} + PRODW'(part_calc);
        end
        if (cmd.terms)
        begin
            pterm_reg <= pterm_calc;
            dterm_reg <= dterm_calc;
            iterm_reg <= iterm_calc;
        end
        if (cmd.sum)
        begin
            pd_reg <= PDW'(pterm_reg) + PDW'(dterm_reg);
        end
        if (cmd.total)
        begin
            total_reg <= TW'(pd_reg) + TW'(iterm_reg);
        end
        if (cmd.out_load)
        begin
            drive_reg     <= drive_calc;
            error_out_reg <= err_reg;
        end
    end

    assign drive     = drive_reg;
    assign error_now = error_out_reg;

endmodule

`default_nettype wire

[rtl/core/pidc_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pidc_ctrl
// Sequencer of the PID step and owner of the stream handshakes.
// ----------------------------------------------------------------------------
`include "pid_controller_clamped_macros.svh"

module pidc_ctrl #(
    parameter int DIV_STEPS = 17,
    parameter int KI_STEPS  = 3
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output pidc_pkg::pidc_cmd_t       cmd,
    input  wire pidc_pkg::pidc_stat_t stat
);

    localparam int CNT_W = $clog2(DIV_STEPS + 1);

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b00_0000_0001,
        ST_IMUL  = 10'b00_0000_0010,
        ST_IADD  = 10'b00_0000_0100,
        ST_DIV   = 10'b00_0000_1000,
        ST_KINIT = 10'b00_0001_0000,
        ST_KMUL  = 10'b00_0010_0000,
        ST_TERMS = 10'b00_0100_0000,
        ST_SUM   = 10'b00_1000_0000,
        ST_TOTAL = 10'b01_0000_0000,
        ST_DONE  = 10'b10_0000_0000
    } pidc_state_t;

    pidc_state_t        state_reg;
    pidc_state_t        state_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic               out_valid_reg;
    logic               out_valid_next;

    // Step through one sample and hand the result to the output register
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && !m_tready;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_IMUL;
                end
            end
            ST_IMUL:
            begin
                cmd.imul   = 1'b1;
                state_next = ST_IADD;
            end
            ST_IADD:
            begin
                cmd.iadd   = 1'b1;
                cnt_next   = '0;
                state_next = stat.ts_zero ? ST_KINIT : ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_KINIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_KINIT:
            begin
                cmd.ki_init = 1'b1;
                cnt_next    = '0;
                state_next  = ST_KMUL;
            end
            ST_KMUL:
            begin
                cmd.ki_step = 1'b1;
                if (cnt_reg == CNT_W'(KI_STEPS - 1))
                begin
                    state_next = ST_TERMS;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_TERMS:
            begin
                cmd.terms  = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_TOTAL;
            end
            ST_TOTAL:
            begin
                cmd.total  = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    // Checks on the sequencer
    `PIDC_ASSERT_IMP(a_out_load_free, cmd.out_load, !out_valid_reg || m_tready, "output overwritten")
    `PIDC_ASSERT_NXT(a_one_request, s_tvalid && s_tready, !s_tready, "second request taken mid-step")
    `PIDC_ASSERT_IMP(a_div_count, state_reg == ST_DIV, cnt_reg < CNT_W'(DIV_STEPS), "divide overrun")
    `PIDC_ASSERT_NXT(a_div_skip, (state_reg == ST_IADD) && stat.ts_zero, state_reg == ST_KINIT, "divide not skipped")

endmodule

`default_nettype wire

[rtl/core/pid_controller_clamped.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pid_controller_clamped
// Clamped integer PID controller, one drive value per measurement request.
// ----------------------------------------------------------------------------
// Usage:
//   Program setpoint, kp, ki, kd, drive_limit and time_step over APB (word
//   index i at byte address 4*i) while no sample is in flight. Each request
//   on the s_ channel carries one measurement; the m_ channel returns one
//   request with the clamped drive and error_now = setpoint - measurement.
//   The time from accept to m_tvalid is set by the bit-serial derivative
//   divider and the 16-bit chunked ki multiply; with a zero time_step the
//   divider is bypassed. One sample is worked at a time; a new request is
//   taken only once the previous result has entered the output register.
//   Reset clears the integral and the previous error and loads register
//   defaults (drive_limit 65535, time_step 1, others 0).
//   If the receiver stalls, the result holds in the output register and the
//   next sample is still accepted and worked; it waits at completion until
//   the output register is taken.
// ----------------------------------------------------------------------------
module pid_controller_clamped #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int ACCUM_WIDTH  = 48
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // APB configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [pidc_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [pidc_pkg::DATA_W-1:0]   pwdata,
    output logic      [pidc_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    // Measurement stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,  // measurement
    // Drive stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [((SAMPLE_WIDTH+24)/8)*8-1:0] m_tdata       // drive, error_now
);

    localparam int OUT_TW = ((SAMPLE_WIDTH + 24) / 8) * 8;

    logic [SAMPLE_WIDTH-1:0]        setpoint;
    pidc_pkg::pidc_gains_t          gains;
    pidc_pkg::pidc_cmd_t            cmd;
    pidc_pkg::pidc_stat_t           stat;
    logic [pidc_pkg::GAIN_W-1:0]    drive;
    logic [SAMPLE_WIDTH:0]          error_now;

    // Configuration registers
    pidc_regs #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .setpoint (setpoint),
        .gains    (gains)
    );

    // Sequencer
    pidc_ctrl #(
        .DIV_STEPS (SAMPLE_WIDTH + 1),
        .KI_STEPS  ((ACCUM_WIDTH + 15) / 16)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // Arithmetic
    pidc_dpath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .ACCUM_WIDTH  (ACCUM_WIDTH)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .setpoint    (setpoint),
        .gains       (gains),
        .measurement (s_tdata[SAMPLE_WIDTH-1:0]),
        .drive       (drive),
        .error_now   (error_now)
    );

    // Pack result fields from bit 0 up
    assign m_tdata = OUT_TW'({error_now, drive});

endmodule

`default_nettype wire

[dv/pid_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_checker
// Watches the APB port and both streams of the clamped PID controller. It
// keeps its own copy of the register file and of the controller state,
// predicts the drive and error for each accepted measurement and compares
// every accepted result, in order, field by field.
// ----------------------------------------------------------------------------
module pid_checker #(
    parameter int ACCUM_WIDTH = 48
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pidc_pkg::ADDR_W-1:0]   paddr,
    input  logic [pidc_pkg::DATA_W-1:0]   pwdata,
    input  logic                          pready,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [15:0]                   s_tdata,   // measurement
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [39:0]                   m_tdata,   // drive, error_now
    output int                            fails = 0,
    output int                            pending = 0,
    output int                            checked = 0,
    output logic                          integral_railed = 1'b0
);
    import pidc_pkg::*;

    localparam longint ACC_MAX = (longint'(1) <<< (ACCUM_WIDTH - 1)) - 1;
    localparam longint ACC_MIN = -ACC_MAX - 1;
    localparam logic [63:0] KI_CAP = 64'd1 << KI_CAP_LSB;
    localparam pidc_gains_t GAINS_RST = '{
        kp: '0, ki: '0, kd: '0, drive_limit: DRIVE_LIMIT_RST, time_step: TIME_STEP_RST
    };

    typedef struct packed {
        logic [15:0]        drive;
        logic signed [16:0] err;
    } pid_result_t;

    // Register mirror and controller state
    logic [15:0]  target = '0;
    pidc_gains_t  gains = GAINS_RST;
    longint       integral_acc = 0;
    longint       last_error = 0;

    pid_result_t  drive_expect_q[$];
    int           fail_total = 0;
    int           results_seen = 0;
    logic         railed = 1'b0;

    // One controller step: update integral and last error, return drive and error
    function automatic pid_result_t pid_step(input logic [15:0] meas_bits);
        pid_result_t res;
        longint      err;
        longint      ts;
        longint      deriv;
        longint      sum;
        longint      iterm;
        longint      total;
        logic [63:0] mag;
        logic [63:0] prod;
        err = longint'($signed(target)) - longint'($signed(meas_bits));
        ts = longint'(gains.time_step);
        // saturating integral
        sum = integral_acc + err * ts;
        if (sum > ACC_MAX)
            sum = ACC_MAX;
        else if (sum < ACC_MIN)
            sum = ACC_MIN;
        integral_acc = sum;
        // derivative truncates toward zero, zero step gives none
        deriv = (ts != 0) ? (err - last_error) / ts : 0;
        last_error = err;
        // integral term held to +/- 2^62
        mag = (integral_acc < 0) ? 64'(-integral_acc) : 64'(integral_acc);
        prod = mag * 64'(gains.ki);
        if (prod > KI_CAP)
            prod = KI_CAP;
        iterm = (integral_acc < 0) ? -longint'(prod) : longint'(prod);
        total = longint'(gains.kp) * err + longint'(gains.kd) * deriv + iterm;
        // clamp to 0..drive_limit
        if (total < 0)
            res.drive = '0;
        else if (total > longint'(gains.drive_limit))
            res.drive = gains.drive_limit;
        else
            res.drive = total[15:0];
        res.err = err[16:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pid_result_t        exp_res;
        logic [15:0]        got_drive;
        logic signed [16:0] got_err;
        if (!rst_n)
        begin
            target = '0;
            gains = GAINS_RST;
            integral_acc = 0;
            last_error = 0;
            drive_expect_q.delete();
            pending <= 0;
        end
        else
        begin
            // mirror register writes, unmapped indexes drop
            if (psel && penable && pwrite && pready)
            begin
                case (pidc_reg_idx_t'(paddr[ADDR_W-1:2]))
                    REG_SETPOINT:    target = pwdata[15:0];
                    REG_KP:          gains.kp = pwdata[15:0];
                    REG_KI:          gains.ki = pwdata[15:0];
                    REG_KD:          gains.kd = pwdata[15:0];
                    REG_DRIVE_LIMIT: gains.drive_limit = pwdata[15:0];
                    REG_TIME_STEP:   gains.time_step = pwdata[15:0];
                    default:         ;
                endcase
            end

            // compare an accepted result with the oldest prediction
            if (m_tvalid && m_tready)
            begin
                got_drive = m_tdata[15:0];
                got_err = m_tdata[32:16];
                results_seen++;
                if (drive_expect_q.size() == 0)
                begin
                    fail_total++;
                    if (fail_total <= 10)
                        $display("%0t: unexpected result drive=%0d error_now=%0d",
                                 $realtime, got_drive, got_err);
                end
                else
                begin
                    exp_res = drive_expect_q.pop_front();
                    if (got_drive !== exp_res.drive || got_err !== exp_res.err)
                    begin
                        fail_total++;
                        if (fail_total <= 10)
                            $display("%0t: result %0d drive exp %0d got %0d, error_now exp %0d got %0d",
                                     $realtime, results_seen, exp_res.drive, got_drive,
                                     exp_res.err, got_err);
                    end
                end
            end

            // predict each accepted measurement request
            if (s_tvalid && s_tready)
                drive_expect_q.push_back(pid_step(s_tdata));

            if (integral_acc == ACC_MAX || integral_acc == ACC_MIN)
                railed = 1'b1;

            pending <= drive_expect_q.size();
            fails <= fail_total;
            checked <= results_seen;
            integral_railed <= railed;
        end
    end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench top for the clamped PID controller. Drives register writes over
// APB and measurement requests on the input stream, throttles the output
// stream, and reports the verdict from the checker's failure and pending
// counts. A short directed part hits the field extremes, zero and small time
// steps and the clamp bounds; random gain settings follow, and the run ends
// with a tail at full rate and the largest gains, steps and errors.
// ----------------------------------------------------------------------------
module tb;
    import pidc_pkg::*;

    localparam logic [IDX_W-1:0] IDX_UNMAPPED_LO = 3'd6;
    localparam logic [IDX_W-1:0] IDX_UNMAPPED_HI = 3'd7;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 170;
    localparam int TAIL_ITEMS = 40;
    localparam int SETTLE_CYCLES = 30;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    wire  [DATA_W-1:0]   prdata;
    wire                 pready;
    logic                s_tvalid = 1'b0;
    wire                 s_tready;
    logic [15:0]         s_tdata = '0;     // measurement
    wire                 m_tvalid;
    logic                m_tready = 1'b0;
    wire  [39:0]         m_tdata;          // drive, error_now

    int   fails;
    int   pending;
    int   checked;
    logic integral_railed;

    logic        src_idle = 1'b0;
    logic        sink_stalls = 1'b0;
    int          sink_left = 0;
    int          quiet_cycles = 0;
    int          samples_sent = 0;
    int          reg_writes = 0;
    int          settings_used = 0;
    logic [15:0] cur_setpoint = '0;

    pid_controller_clamped dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    pid_checker chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .fails           (fails),
        .pending         (pending),
        .checked         (checked),
        .integral_railed (integral_railed)
    );

    always #10 clk = ~clk;

    // Throttle the result stream with random bursts of stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            sink_left <= 0;
        end
        else if (sink_left > 0)
            sink_left <= sink_left - 1;
        else if (sink_stalls && $urandom_range(0, 2) == 0)
        begin
            m_tready <= 1'b0;
            sink_left <= $urandom_range(0, 4);
        end
        else
        begin
            m_tready <= 1'b1;
            sink_left <= $urandom_range(0, 6);
        end
    end

    // Abort when nothing moves for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles, %0d results pending",
                     quiet_cycles, pending);
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Setup and access cycle; upper data bits carry junk the block must drop
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [15:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {16'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        reg_writes++;
        @(posedge clk);
    endtask

    task automatic program_gains(input logic [15:0] sp, input logic [15:0] kp,
                                 input logic [15:0] ki, input logic [15:0] kd,
                                 input logic [15:0] limit, input logic [15:0] step);
        cur_setpoint = sp;
        write_reg(REG_SETPOINT, sp);
        write_reg(REG_KP, kp);
        write_reg(REG_KI, ki);
        write_reg(REG_KD, kd);
        write_reg(REG_DRIVE_LIMIT, limit);
        write_reg(REG_TIME_STEP, step);
        settings_used++;
    endtask

    // Present one measurement request, hold it until taken, then maybe idle
    task automatic send_sample(input logic [15:0] meas);
        s_tvalid <= 1'b1;
        s_tdata <= meas;
        do @(posedge clk); while (!s_tready);
        samples_sent++;
        if (src_idle && $urandom_range(0, 2) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    // Drop the request line and hold until every result is back
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(1, 4));
            3:       return 16'($urandom_range(1, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_setpoint();
        case ($urandom_range(0, 4))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return '0;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_limit();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_step();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 16'd1;
            2:       return 16'hFFFF;
            3:       return 16'($urandom_range(2, 16));
            default: return 16'($urandom);
        endcase
    endfunction

    // Extremes, values near the target, or anything at all
    function automatic logic [15:0] rand_measurement(input logic [15:0] sp);
        int near;
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2, 3:
            begin
                near = int'($signed(sp)) + int'($urandom_range(0, 64)) - 32;
                if (near > 32767)
                    near = 32767;
                else if (near < -32768)
                    near = -32768;
                return near[15:0];
            end
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        int extra;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset defaults: zero gains, unit step
        send_sample(16'h0000);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        drain();

        // Largest positive error, clamp at full limit; unmapped writes drop
        program_gains(16'h7FFF, 16'd1, 16'd0, 16'd0, 16'hFFFF, 16'd1);
        write_reg(IDX_UNMAPPED_LO, 16'($urandom));
        write_reg(IDX_UNMAPPED_HI, 16'($urandom));
        send_sample(16'h8000);
        send_sample(16'hFFFF);
        send_sample(16'h7FFF);
        send_sample(16'h5555);
        send_sample(16'hAAAA);
        drain();

        // Largest negative error; zero limit forces zero drive
        program_gains(16'h8000, 16'hFFFF, 16'd1, 16'hFFFF, 16'h0000, 16'd1);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        drain();

        // Zero time step: no integral, no derivative, last error still moves
        program_gains(16'd100, 16'd2, 16'd3, 16'd4, 16'hFFFF, 16'd0);
        send_sample(16'd100);
        send_sample(-16'sd100);
        send_sample(16'd300);
        send_sample(16'd0);
        drain();

        // Derivative truncation toward zero with a step of three
        program_gains(16'd0, 16'd10, 16'd0, 16'd1, 16'hFFFF, 16'd3);
        send_sample(-16'sd10);
        send_sample(-16'sd3);
        send_sample(-16'sd8);
        drain();

        // Random gain settings, idling varied per phase
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            program_gains(pick_setpoint(), pick_gain(), pick_gain(), pick_gain(),
                          pick_limit(), pick_step());
            src_idle = (ph % 3 != 2);
            sink_stalls <= (ph % 4 != 3);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                send_sample(rand_measurement(cur_setpoint));
                if ($urandom_range(0, 63) == 0)
                    drain();
            end
            drain();
        end

        // Full-rate tail with the largest gains and step, largest errors first
        src_idle = 1'b0;
        sink_stalls <= 1'b0;
        program_gains(16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd50000, 16'hFFFF);
        for (extra = 0; extra < TAIL_ITEMS; extra++)
        begin
            if (extra < TAIL_ITEMS / 2)
                send_sample(16'h8000 + 16'($urandom_range(0, 15)));
            else
                send_sample(rand_measurement(cur_setpoint));
        end
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d measurements over %0d gain settings (%0d register writes),",
                 samples_sent, settings_used, reg_writes);
        $display("checked %0d results; integral saturation %0s.",
                 checked, integral_railed ? "reached" : "not reached");
        if (fails == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/pidc_pkg.sv
rtl/core/pidc_regs.sv
rtl/core/pidc_dpath.sv
rtl/core/pidc_ctrl.sv
rtl/core/pid_controller_clamped.sv
dv/pid_checker.sv
dv/tb.sv
